>>> sv/rwcp_pkg.sv
// shared types and constants for the riff/wave chunk parser
`timescale 1ns / 1ps
`default_nettype none

package rwcp_pkg;

   // result status codes
   localparam logic [1:0] ST_DATA    = 2'd0;
   localparam logic [1:0] ST_BAD_TAG = 2'd1;
   localparam logic [1:0] ST_END     = 2'd2;

   // result queue geometry
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [1:0] status;
      logic       last_in_chunk;
   } rsp_type;

   // up to two results made by one request, slot 0 first
   typedef struct packed {
      logic [1:0] count;
      rsp_type    r0;
      rsp_type    r1;
   } push_type;

endpackage

`default_nettype wire

>>> sv/rwcp_parse.sv
// chunk walker: parse state and per-byte next-state logic
`timescale 1ns / 1ps
`default_nettype none

module rwcp_parse
   import rwcp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       take,
   input  wire logic [7:0] in_byte,
   input  wire logic       file_start,
   output push_type        push
);

   localparam logic [2:0] PH_RIFF_TAG  = 3'd0;
   localparam logic [2:0] PH_RIFF_SIZE = 3'd1;
   localparam logic [2:0] PH_CHUNK_ID  = 3'd2;
   localparam logic [2:0] PH_CHUNK_SZ  = 3'd3;
   localparam logic [2:0] PH_PAYLOAD   = 3'd4;
   localparam logic [2:0] PH_PAD       = 3'd5;
   localparam logic [2:0] PH_DONE      = 3'd6;
   localparam logic [2:0] PH_ERROR     = 3'd7;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  bif_ff, bif_in;
   logic [31:0] field_ff, field_in;
   logic [31:0] riff_left_ff, riff_left_in;
   logic [31:0] chunk_left_ff, chunk_left_in;
   logic        pad_ff, pad_in;
   logic        data_chunk_ff, data_chunk_in;

   logic [2:0]  ph;
   logic [1:0]  bif;
   logic [31:0] shifted;
   logic        complete;
   logic        walking;
   logic        data_out;
   rsp_type     data_rsp;
   rsp_type     end_rsp;
   rsp_type     bad_rsp;

   always_comb begin
      // a file start restarts the parse on this very byte
      ph       = file_start ? PH_RIFF_TAG : phase_ff;
      bif      = file_start ? 2'd0 : bif_ff;
      shifted  = {in_byte, field_ff[31:8]};
      complete = (bif == 2'd3);
      walking  = (ph == PH_CHUNK_ID) || (ph == PH_CHUNK_SZ) ||
                 (ph == PH_PAYLOAD) || (ph == PH_PAD);

      phase_in      = ph;
      bif_in        = bif;
      field_in      = field_ff;
      riff_left_in  = riff_left_ff;
      chunk_left_in = chunk_left_ff;
      pad_in        = pad_ff;
      data_chunk_in = data_chunk_ff;
      data_out      = 1'b0;

      data_rsp = '{payload_byte: in_byte, status: ST_DATA,
                   last_in_chunk: (chunk_left_ff == 32'd1)};
      end_rsp  = '{payload_byte: 8'd0, status: ST_END, last_in_chunk: 1'b0};
      bad_rsp  = '{payload_byte: 8'd0, status: ST_BAD_TAG, last_in_chunk: 1'b0};
      push     = '{count: 2'd0, r0: '0, r1: '0};

      unique case (ph)
         PH_RIFF_TAG: begin
            field_in = shifted;
            bif_in   = bif + 2'd1;
            if (complete) begin
               if (shifted == TAG_RIFF) begin
                  phase_in = PH_RIFF_SIZE;
               end else begin
                  phase_in   = PH_ERROR;
                  push.count = 2'd1;
                  push.r0    = bad_rsp;
               end
            end
         end
         PH_RIFF_SIZE: begin
            field_in = shifted;
            bif_in   = bif + 2'd1;
            if (complete) begin
               riff_left_in = shifted;
               if (shifted == 32'd0) begin
                  phase_in   = PH_DONE;
                  push.count = 2'd1;
                  push.r0    = end_rsp;
               end else begin
                  phase_in = PH_CHUNK_ID;
               end
            end
         end
         PH_CHUNK_ID: begin
            field_in = shifted;
            bif_in   = bif + 2'd1;
            // the wave form tag has no size field
            if (complete && (shifted != TAG_WAVE)) begin
               data_chunk_in = (shifted == TAG_DATA);
               phase_in      = PH_CHUNK_SZ;
            end
         end
         PH_CHUNK_SZ: begin
            field_in = shifted;
            bif_in   = bif + 2'd1;
            if (complete) begin
               chunk_left_in = shifted;
               pad_in        = shifted[0];
               phase_in      = (shifted == 32'd0) ? PH_CHUNK_ID : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            chunk_left_in = chunk_left_ff - 32'd1;
            if (data_chunk_ff) begin
               data_out   = 1'b1;
               push.count = 2'd1;
               push.r0    = data_rsp;
            end
            if (chunk_left_ff == 32'd1) begin
               phase_in = pad_ff ? PH_PAD : PH_CHUNK_ID;
            end
         end
         PH_PAD: begin
            pad_in   = 1'b0;
            phase_in = PH_CHUNK_ID;
         end
         default: begin
         end
      endcase

      // every byte inside the form counts against the riff size
      if (walking) begin
         riff_left_in = riff_left_ff - 32'd1;
         if (riff_left_ff == 32'd1) begin
            phase_in = PH_DONE;
            if (data_out) begin
               push.count = 2'd2;
               push.r1    = end_rsp;
            end else begin
               push.count = 2'd1;
               push.r0    = end_rsp;
            end
         end
      end

      if (!take) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RIFF_TAG;
         bif_ff   <= 2'd0;
      end else if (take) begin
         phase_ff <= phase_in;
         bif_ff   <= bif_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         field_ff      <= field_in;
         riff_left_ff  <= riff_left_in;
         chunk_left_ff <= chunk_left_in;
         pad_ff        <= pad_in;
         data_chunk_ff <= data_chunk_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/rwcp_rsp_queue.sv
// result queue: takes up to two results a cycle, gives one unless rsp_stall holds it
`timescale 1ns / 1ps
`default_nettype none

module rwcp_rsp_queue
   import rwcp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire push_type   push,
   output logic            no_room,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp
);

   rsp_type             mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                pop;

   assign rsp_valid = (cnt_ff != '0);
   assign rsp       = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   // keep room for two results whatever the drain side does
   assign no_room   = (cnt_ff > QCNT_W'(QDEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      cnt_in    = cnt_ff + QCNT_W'(push.count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + QPTR_W'(1)] <= push.r1;
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QDEPTH))
      else $error("result queue overfilled");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (cnt_ff <= QCNT_W'(QDEPTH - 2)))
      else $error("push into queue without room");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd3)
      else $error("more than two results from one request");
`endif

endmodule

`default_nettype wire

>>> sv/riff_wav_chunk_parser_unit.sv
// top level of the riff/wave chunk parser
// usage:
//   feed the file one byte per request on req_in_byte; raise req_file_start
//   with the first byte of each file to restart the parse
//   each request gives zero, one or two results on the rsp_ channel:
//     status data    - a payload byte of a data chunk, last_in_chunk on its end
//     status bad tag - the first four bytes were not the riff tag
//     status end     - the riff size has been used up (after any data result
//                      of the same byte)
//   after a bad tag or the end, bytes are swallowed until the next file start
// results are written into the queue registers when their request is accepted
// throughput: one request per cycle while req_stall is low; the walker updates
//   its phase and byte counters on each request, results go through a four-entry
//   queue that drains one result per cycle while rsp_stall is low
// req_stall rises while the queue holds more than two results, so a byte
//   giving two results (last data byte plus end) fills it one entry faster
// reset: synchronous, clears the parse phase and empties the queue
// when the receiver stalls, the offered result holds and the queue fills,
//   then req_stall backs up the request side
`timescale 1ns / 1ps
`default_nettype none

module riff_wav_chunk_parser_unit
   import rwcp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_file_start,

   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_payload_byte,
   output logic [1:0]      rsp_status,
   output logic            rsp_last_in_chunk
);

   logic     take;
   logic     no_room;
   push_type push;
   rsp_type  rsp;

   // request handshake
   assign req_stall = no_room;
   assign take      = req_valid && !no_room;

   // byte walker: phase, field assembly, riff and chunk counters
   rwcp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .in_byte    (req_in_byte),
      .file_start (req_file_start),
      .push       (push)
   );

   // results wait here until the receiver takes them
   rwcp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .no_room   (no_room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_payload_byte  = rsp.payload_byte;
   assign rsp_status        = rsp.status;
   assign rsp_last_in_chunk = rsp.last_in_chunk;

endmodule

`default_nettype wire
